// ----- src/mdam_pkg.sv -----
// Package: shared types and constants of the modulated delay block.
package mdam_pkg;

  typedef enum logic [1:0] {
    OP_PROCESS = 2'd0,
    OP_GAIN    = 2'd1,
    OP_DELAY   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_LERP,
    ST_MUL,
    ST_OUT
  } state_e;

  localparam int unsigned SampleW = 16;
  localparam int unsigned TableAw = 8;
  localparam int unsigned PhaseW  = 32;
  localparam int unsigned AccW    = 18;
  localparam int unsigned StepCntW = 4;

endpackage

// ----- src/mdam_in_if.sv -----
// Interface: input channel carrying process and table-write beats.
interface mdam_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [7:0]          table_index;
  logic signed [15:0]  table_value;
  logic signed [15:0]  sample;

  modport source (output valid, operation, table_index, table_value, sample, input ready);
  modport sink   (input valid, operation, table_index, table_value, sample, output ready);
endinterface

// ----- src/mdam_out_if.sv -----
// Interface: output channel carrying processed sample beats.
interface mdam_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  out_sample;

  modport source (output valid, out_sample, input ready);
  modport sink   (input valid, out_sample, output ready);
endinterface

// ----- src/mdam_ram.sv -----
// Generic RAM: one write port, one read port with registered read data.
module mdam_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/modulated_delay_amplitude_mod_top.sv -----
// Top level: modulated fractional delay with interpolated gain, bit-serial arithmetic.
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid/ready   | operation, table_index, table_value, sample
//  out_o   | out | valid/ready   | out_sample
//  cfg     | in  | cfg_we_i      | cfg_data_i (phase_step)
//
// A table write is done as the beat is accepted, without leaving idle. A process beat
// runs: accept, three RAM read states, serial interpolation (one bit of each weight a
// cycle), serial gain multiply over the gain bits, then load of the output.
// After reset a clearing pass steps through every ring address and zeroes the ring
// and both tables; no input beat is taken meanwhile. Input is taken while a result
// waits in the output register; a stalled output holds the next result back.
module modulated_delay_amplitude_mod_top #(
  parameter int RING_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  mdam_in_if.sink     in_i,
  mdam_out_if.source  out_o
);

  localparam int Aw = $clog2(RING_DEPTH);

  mdam_pkg::state_e state_q, state_d;

  logic [mdam_pkg::PhaseW-1:0] step_q, phase_q;
  logic [Aw-1:0]               wp_q, wpc_q, rp1_q, clr_q;
  logic [7:0]                  idx_q, f2_q;
  logic [15:0]                 frac_q;
  logic signed [15:0]          g0_q, g1_q, a_q, b_q;
  logic signed [mdam_pkg::AccW-1:0] hi_s_q, hi_g_q, macc_q;
  logic [15:0]                 ts_q, tg_q;
  logic [mdam_pkg::StepCntW-1:0] cnt_q;
  logic                        out_valid_q;
  logic signed [15:0]          out_data_q;

  logic                        accept;
  logic                        out_load;
  logic                        ring_we, gain_we, delay_we;
  logic [Aw-1:0]               ring_waddr, ring_raddr;
  logic [7:0]                  gain_waddr, gain_raddr, delay_waddr, delay_raddr;
  logic [15:0]                 ring_wdata, gain_wdata, delay_wdata;
  logic [15:0]                 ring_rd, gain_rd, delay_rd;
  logic signed [7:0]           off;
  logic [Aw-1:0]               rp1_d;
  logic signed [mdam_pkg::AccW-1:0] sum_s, sum_g, sum_m;

  mdam_ram #(.Width(16), .Depth(RING_DEPTH)) u_ring (
    .clk_i, .we_i(ring_we), .waddr_i(ring_waddr), .wdata_i(ring_wdata),
    .raddr_i(ring_raddr), .rdata_o(ring_rd)
  );
  mdam_ram #(.Width(16), .Depth(256)) u_gain (
    .clk_i, .we_i(gain_we), .waddr_i(gain_waddr), .wdata_i(gain_wdata),
    .raddr_i(gain_raddr), .rdata_o(gain_rd)
  );
  mdam_ram #(.Width(16), .Depth(256)) u_delay (
    .clk_i, .we_i(delay_we), .waddr_i(delay_waddr), .wdata_i(delay_wdata),
    .raddr_i(delay_raddr), .rdata_o(delay_rd)
  );

  assign in_i.ready = (state_q == mdam_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_data_q;
  assign out_load   = (state_q == mdam_pkg::ST_OUT) && (!out_valid_q || out_o.ready);

  assign off   = signed'(delay_rd[15:8]);
  assign rp1_d = wpc_q - Aw'(off);

  // One weight bit per cycle: pick b where the bit is set, a where it is clear.
  assign sum_s = hi_s_q + (ts_q[0] ? mdam_pkg::AccW'(b_q) : mdam_pkg::AccW'(a_q));
  assign sum_g = hi_g_q + (tg_q[0] ? mdam_pkg::AccW'(g1_q) : mdam_pkg::AccW'(g0_q));
  // Gain bit 15 carries negative weight: subtract on the last step.
  assign sum_m = (cnt_q == '1)
      ? macc_q - (hi_g_q[0] ? mdam_pkg::AccW'(signed'(hi_s_q[15:0])) : '0)
      : macc_q + (hi_g_q[0] ? mdam_pkg::AccW'(signed'(hi_s_q[15:0])) : '0);

  always_comb begin
    state_d     = state_q;
    ring_we     = 1'b0;
    gain_we     = 1'b0;
    delay_we    = 1'b0;
    ring_waddr  = wp_q;
    ring_wdata  = in_i.sample;
    gain_waddr  = in_i.table_index;
    gain_wdata  = in_i.table_value;
    delay_waddr = in_i.table_index;
    delay_wdata = in_i.table_value;
    ring_raddr  = rp1_q;
    gain_raddr  = phase_q[31:24];
    delay_raddr = phase_q[31:24];
    unique case (state_q)
      mdam_pkg::ST_CLEAR: begin
        ring_we     = 1'b1;
        gain_we     = 1'b1;
        delay_we    = 1'b1;
        ring_waddr  = clr_q;
        gain_waddr  = clr_q[7:0];
        delay_waddr = clr_q[7:0];
        ring_wdata  = '0;
        gain_wdata  = '0;
        delay_wdata = '0;
        if (clr_q == '1) begin
          state_d = mdam_pkg::ST_IDLE;
        end
      end
      mdam_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_i.operation)
            mdam_pkg::OP_PROCESS: begin
              ring_we = 1'b1;
              state_d = mdam_pkg::ST_RD1;
            end
            mdam_pkg::OP_GAIN:  gain_we  = 1'b1;
            mdam_pkg::OP_DELAY: delay_we = 1'b1;
            default: ;
          endcase
        end
      end
      mdam_pkg::ST_RD1: begin
        gain_raddr = idx_q + 8'd1;
        ring_raddr = rp1_d - Aw'(1);
        state_d    = mdam_pkg::ST_RD2;
      end
      mdam_pkg::ST_RD2: begin
        ring_raddr = rp1_q;
        state_d    = mdam_pkg::ST_RD3;
      end
      mdam_pkg::ST_RD3: state_d = mdam_pkg::ST_LERP;
      mdam_pkg::ST_LERP: begin
        if (cnt_q == '1) begin
          state_d = mdam_pkg::ST_MUL;
        end
      end
      mdam_pkg::ST_MUL: begin
        if (cnt_q == '1) begin
          state_d = mdam_pkg::ST_OUT;
        end
      end
      mdam_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = mdam_pkg::ST_IDLE;
        end
      end
      default: state_d = mdam_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mdam_pkg::ST_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      phase_q     <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        step_q <= cfg_data_i;
      end
      if (state_q == mdam_pkg::ST_CLEAR) begin
        clr_q <= clr_q + Aw'(1);
      end
      if (accept && in_i.operation == mdam_pkg::OP_PROCESS) begin
        phase_q <= phase_q + step_q;
        wp_q    <= wp_q + Aw'(1);
      end
      if (state_q == mdam_pkg::ST_LERP || state_q == mdam_pkg::ST_MUL) begin
        cnt_q <= cnt_q + mdam_pkg::StepCntW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mdam_pkg::ST_IDLE: begin
        idx_q  <= phase_q[31:24];
        frac_q <= phase_q[23:8];
        wpc_q  <= wp_q;
      end
      mdam_pkg::ST_RD1: begin
        g0_q  <= signed'(gain_rd);
        f2_q  <= delay_rd[7:0];
        rp1_q <= rp1_d;
      end
      mdam_pkg::ST_RD2: begin
        g1_q <= signed'(gain_rd);
        a_q  <= signed'(ring_rd);
      end
      mdam_pkg::ST_RD3: begin
        b_q    <= signed'(ring_rd);
        hi_s_q <= '0;
        hi_g_q <= '0;
        macc_q <= '0;
        ts_q   <= {f2_q, 8'd0};
        tg_q   <= frac_q;
      end
      mdam_pkg::ST_LERP: begin
        hi_s_q <= sum_s >>> 1;
        hi_g_q <= sum_g >>> 1;
        ts_q   <= ts_q >> 1;
        tg_q   <= tg_q >> 1;
      end
      mdam_pkg::ST_MUL: begin
        // Shift the gain out LSB first; hold the scale on the last step.
        hi_g_q <= hi_g_q >> 1;
        if (cnt_q == '1) begin
          macc_q <= sum_m;
        end else begin
          macc_q <= sum_m >>> 1;
        end
      end
      mdam_pkg::ST_OUT: begin
        if (out_load) begin
          out_data_q <= signed'(macc_q[15:0]);
        end
      end
      default: ;
    endcase
  end

endmodule
